FILE: sv/ttscf_pkg.sv
// Shared types, constants and helpers for the text-to-speech command framer.
package ttscf_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hFD;
    localparam logic [7:0] CMD_BYTE = 8'h01;
    localparam logic [7:0] ENC_ALT  = 8'h04;
    localparam logic [7:0] ENC_STD  = 8'h00;
    localparam logic [7:0] NUL_BYTE = 8'h00;
    localparam logic [8:0] MAX_TEXT = 9'd256;

    localparam int unsigned SLOT_COUNT = 8;

    // Frame byte positions generated for one input transaction, in emission order.
    typedef enum logic [2:0] {
        SLOT_HDR,
        SLOT_LEN_HI,
        SLOT_LEN_LO,
        SLOT_CMD,
        SLOT_ENC,
        SLOT_TEXT,
        SLOT_NUL,
        SLOT_CSUM
    } t_slot;

    typedef logic [SLOT_COUNT-1:0] t_slot_mask;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_seq_out;

    function automatic t_slot first_slot(input t_slot_mask mask);
        t_slot res;
        res = SLOT_CSUM;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (mask[i]) begin
                res = t_slot'(i[2:0]);
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/tts_command_framer.sv
// Top level of the text-to-speech command framer: config register and output register.
//
//  channel   direction  handshake                 payload
//  text      in         i_valid / o_ready         i_text_byte, i_text_length,
//                                                 i_ends_with_nul, i_is_last
//  frame     out        o_valid / i_ready         o_frame_byte, o_frame_last
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data (encoding select)
//
// One frame byte leaves per cycle while i_ready is high; the sequencer sets the pace.
// A middle transaction yields only its text byte, so text likewise streams one per cycle.
// A message's first transaction yields 6 bytes (header bytes, text), plus 1 or 2 more
// when it also closes the frame; an empty text gives 7 bytes; a last one gives 2 or 3.
// Synchronous active-low reset; the frame output register decouples stalls.
module tts_command_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic [8:0] i_text_length,
    input  logic       i_ends_with_nul,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import ttscf_pkg::*;

    logic       r_enc;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;
    t_seq_out   seq;
    logic       take;
    logic       in_ready;

    assign take = seq.valid && (!r_ov || i_ready);

    ttscf_frame_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (i_valid && in_ready),
        .i_text_byte     (i_text_byte),
        .i_text_length   (i_text_length),
        .i_ends_with_nul (i_ends_with_nul),
        .i_is_last       (i_is_last),
        .i_enc_sel       (r_enc),
        .i_take          (take),
        .o_in_ready      (in_ready),
        .o_seq           (seq)
    );

    assign o_ready      = in_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_ov;
    assign o_frame_byte = r_ob;
    assign o_frame_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enc <= i_cfg_data;
            end
            if (take) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ob <= seq.data;
            r_ol <= seq.last;
        end
    end

endmodule

FILE: sv/ttscf_frame_seq.sv
// Item buffer and byte sequencer: expands each text transaction into frame bytes.
module ttscf_frame_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [7:0]          i_text_byte,
    input  logic [8:0]          i_text_length,
    input  logic                i_ends_with_nul,
    input  logic                i_is_last,
    input  logic                i_enc_sel,
    input  logic                i_take,
    output logic                o_in_ready,
    output ttscf_pkg::t_seq_out o_seq
);
    import ttscf_pkg::*;

    logic       r_bv;
    logic [7:0] r_byte;
    logic [8:0] r_len;
    logic       r_ewn;
    logic       r_last;
    t_slot_mask r_sent;
    logic       r_in_message;
    logic       r_nul;
    logic [7:0] r_xor;

    logic       first;
    logic       zero_len;
    logic       closing;
    logic       nul_eff;
    logic [8:0] cnt;
    logic [15:0] len16;
    t_slot_mask en;
    t_slot_mask pending;
    t_slot_mask cur_bit;
    t_slot      cur;
    logic [7:0] cur_byte;
    logic       step;
    logic       finish;

    always_comb begin
        first    = !r_in_message;
        zero_len = first && (r_len == 9'd0);
        closing  = zero_len || (!zero_len && r_last);
        nul_eff  = first ? ((r_len != 9'd0) && r_ewn) : r_nul;
        cnt      = (r_len > MAX_TEXT) ? MAX_TEXT : r_len;
        len16    = 16'd3 + {7'd0, cnt} + (nul_eff ? 16'd0 : 16'd1);

        en                = '0;
        en[SLOT_HDR]      = first;
        en[SLOT_LEN_HI]   = first;
        en[SLOT_LEN_LO]   = first;
        en[SLOT_CMD]      = first;
        en[SLOT_ENC]      = first;
        en[SLOT_TEXT]     = !zero_len;
        en[SLOT_NUL]      = closing && !nul_eff;
        en[SLOT_CSUM]     = closing;

        pending = en & ~r_sent;
        cur     = first_slot(pending);
        cur_bit = '0;
        cur_bit[cur] = 1'b1;

        case (cur)
            SLOT_HDR:    cur_byte = HDR_BYTE;
            SLOT_LEN_HI: cur_byte = len16[15:8];
            SLOT_LEN_LO: cur_byte = len16[7:0];
            SLOT_CMD:    cur_byte = CMD_BYTE;
            SLOT_ENC:    cur_byte = i_enc_sel ? ENC_ALT : ENC_STD;
            SLOT_TEXT:   cur_byte = r_byte;
            SLOT_NUL:    cur_byte = NUL_BYTE;
            SLOT_CSUM:   cur_byte = r_xor;
            default:     cur_byte = NUL_BYTE;
        endcase

        step   = r_bv && i_take;
        finish = step && ((pending & ~cur_bit) == '0);
    end

    assign o_in_ready  = !r_bv || finish;
    assign o_seq.valid = r_bv;
    assign o_seq.data  = cur_byte;
    assign o_seq.last  = (cur == SLOT_CSUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv         <= 1'b0;
            r_sent       <= '0;
            r_in_message <= 1'b0;
            r_nul        <= 1'b0;
            r_xor        <= 8'd0;
        end else begin
            if (i_load) begin
                r_bv <= 1'b1;
            end else if (finish) begin
                r_bv <= 1'b0;
            end

            if (i_load || finish) begin
                r_sent <= '0;
            end else if (step) begin
                r_sent <= r_sent | cur_bit;
            end

            if (finish) begin
                r_in_message <= !closing;
                r_nul        <= closing ? 1'b0 : nul_eff;
            end

            if (step) begin
                case (cur)
                    SLOT_HDR:    r_xor <= r_xor;
                    SLOT_LEN_HI: r_xor <= cur_byte;
                    SLOT_CSUM:   r_xor <= 8'd0;
                    default:     r_xor <= r_xor ^ cur_byte;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_text_byte;
            r_len  <= i_text_length;
            r_ewn  <= i_ends_with_nul;
            r_last <= i_is_last;
        end
    end

    a_pending_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bv |-> (pending != '0))
        else $error("buffered transaction has no frame byte left");

    a_hdr_only_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bv && cur == SLOT_HDR) |-> !r_in_message)
        else $error("header issued inside an open message");

    a_csum_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && cur == SLOT_CSUM) |=> (!r_in_message && r_xor == 8'd0 && !r_nul))
        else $error("checksum byte did not close the message");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_bv || finish))
        else $error("transaction loaded over a busy buffer");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the text-to-speech command framer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ttscf_pkg::*;

    localparam int unsigned STALL_LIMIT    = 1000;
    localparam int unsigned RX_HOLD_CYCLES = 80;
    localparam int unsigned RANDOM_ITEMS   = 25;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [8:0] text_len;
        logic       ends_nul;
        logic       is_last;
    } t_text_item;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_frame_beat;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_ready;
    logic [7:0] i_text_byte     = '0;
    logic [8:0] i_text_length   = '0;
    logic       i_ends_with_nul = 1'b0;
    logic       i_is_last       = 1'b0;
    logic       o_valid;
    logic       i_ready         = 1'b0;
    logic [7:0] o_frame_byte;
    logic       o_frame_last;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data      = 1'b0;

    t_text_item  text_pending[$];
    t_frame_beat frame_expected[$];

    int unsigned text_queued      = 0;
    int unsigned text_accepted    = 0;
    int unsigned mismatch_count   = 0;
    int unsigned tx_idle_pct      = 0;
    int unsigned rx_idle_pct      = 0;
    int unsigned rx_hold_requests = 0;
    int unsigned rx_hold_seen     = 0;
    int unsigned rx_hold_cnt      = 0;
    int unsigned stall_cycles     = 0;

    // framer state as seen by the predictor
    logic       enc_sel  = 1'b0;
    logic       msg_open = 1'b0;
    logic [7:0] csum_acc = '0;
    logic       nul_held = 1'b0;

    tts_command_framer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_text_byte     (i_text_byte),
        .i_text_length   (i_text_length),
        .i_ends_with_nul (i_ends_with_nul),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_byte    (o_frame_byte),
        .o_frame_last    (o_frame_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void append_beat(logic [7:0] b, logic fin);
        frame_expected.insert(frame_expected.size(), t_frame_beat'{data: b, fin: fin});
    endfunction

    function automatic void emit_frame_byte(logic [7:0] b, logic fin);
        append_beat(b, fin);
        if (!fin) begin
            csum_acc = csum_acc ^ b;
        end
    endfunction

    function automatic void close_expected_frame();
        if (!nul_held) begin
            emit_frame_byte(NUL_BYTE, 1'b0);
        end
        emit_frame_byte(csum_acc, 1'b1);
        msg_open = 1'b0;
        csum_acc = '0;
        nul_held = 1'b0;
    endfunction

    function automatic void frame_text_item(t_text_item it);
        logic [8:0]  cnt;
        logic [15:0] len;
        if (!msg_open) begin
            cnt      = (it.text_len > MAX_TEXT) ? MAX_TEXT : it.text_len;
            csum_acc = '0;
            nul_held = (it.text_len != 0) && it.ends_nul;
            len      = 16'd3 + 16'(cnt) + (nul_held ? 16'd0 : 16'd1);
            append_beat(HDR_BYTE, 1'b0);
            emit_frame_byte(len[15:8], 1'b0);
            emit_frame_byte(len[7:0], 1'b0);
            emit_frame_byte(CMD_BYTE, 1'b0);
            emit_frame_byte(enc_sel ? ENC_ALT : ENC_STD, 1'b0);
            if (it.text_len == 0) begin
                close_expected_frame();
                return;
            end
            msg_open = 1'b1;
        end
        emit_frame_byte(it.text_byte, 1'b0);
        if (it.is_last) begin
            close_expected_frame();
        end
    endfunction

    always @(posedge i_clk) begin : text_driver
        t_text_item nxt;
        if (i_valid && o_ready) begin
            frame_text_item('{text_byte: i_text_byte, text_len: i_text_length,
                              ends_nul: i_ends_with_nul, is_last: i_is_last});
            text_accepted++;
        end
        if (!i_valid || o_ready) begin
            if (text_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = text_pending.pop_front();
                i_valid         <= 1'b1;
                i_text_byte     <= nxt.text_byte;
                i_text_length   <= nxt.text_len;
                i_ends_with_nul <= nxt.ends_nul;
                i_is_last       <= nxt.is_last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : frame_monitor
        t_frame_beat exp_b;
        if (o_valid && i_ready) begin
            if (frame_expected.size() == 0) begin
                $display("%0t: unexpected frame byte: expected none, got %02h last %0b",
                         $time, o_frame_byte, o_frame_last);
                mismatch_count++;
            end else begin
                exp_b = frame_expected.pop_front();
                if (o_frame_byte !== exp_b.data || o_frame_last !== exp_b.fin) begin
                    $display("%0t: frame mismatch: expected %02h last %0b, got %02h last %0b",
                             $time, exp_b.data, exp_b.fin, o_frame_byte, o_frame_last);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold_seen != rx_hold_requests) begin
            rx_hold_seen <= rx_hold_requests;
            rx_hold_cnt  <= RX_HOLD_CYCLES;
            i_ready      <= 1'b0;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tts_command_framer regression: fail");
            $finish;
        end
    end

    task automatic queue_item(logic [7:0] b, logic [8:0] len, logic nul_flag, logic fin);
        text_pending.insert(text_pending.size(),
                            t_text_item'{text_byte: b, text_len: len, ends_nul: nul_flag,
                                         is_last: fin});
        text_queued++;
    endtask

    task automatic queue_message(int unsigned n_items, logic [8:0] len, logic nul_flag);
        logic [7:0] b;
        logic       fin;
        for (int unsigned k = 0; k < n_items; k++) begin
            b   = 8'($urandom);
            fin = (len == 0) ? 1'($urandom) : (k == n_items - 1);
            if (fin && nul_flag) begin
                b = NUL_BYTE;
            end
            if (k == 0) begin
                queue_item(b, len, nul_flag, fin);
            end else begin
                queue_item(b, 9'($urandom), 1'($urandom), fin);
            end
        end
    endtask

    task automatic queue_random_messages(int unsigned budget);
        int unsigned n;
        int unsigned sel;
        logic [8:0]  len;
        int unsigned queued;
        queued = 0;
        while (queued < budget) begin
            sel = $urandom_range(99);
            n   = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            if (sel < 8) begin
                n   = 1;
                len = '0;
            end else if (sel < 22) begin
                len = 9'($urandom);
            end else begin
                len = 9'(n);
            end
            queue_message(n, len, 1'($urandom));
            queued += n;
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (text_accepted != text_queued || frame_expected.size() != 0);
    endtask

    task automatic write_encoding(logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        enc_sel = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty texts, single bytes, ignored later fields, length edge cases
        queue_item(8'hFF, 9'd0,   1'b1, 1'b1);
        queue_item(8'h00, 9'd0,   1'b0, 1'b0);
        queue_item(8'h00, 9'd1,   1'b1, 1'b1);
        queue_item(8'hFF, 9'd1,   1'b0, 1'b1);
        queue_item(8'hAA, 9'd3,   1'b0, 1'b0);
        queue_item(8'h55, 9'h1FF, 1'b1, 1'b0);
        queue_item(8'hFF, 9'd0,   1'b0, 1'b1);
        queue_item(8'h01, 9'd256, 1'b0, 1'b0);
        queue_item(8'h80, 9'd0,   1'b0, 1'b1);
        queue_item(8'h7F, 9'h1FF, 1'b1, 1'b0);
        queue_item(8'h00, 9'd0,   1'b0, 1'b1);
        queue_item(8'h12, 9'd2,   1'b0, 1'b0);
        queue_item(8'h34, 9'd0,   1'b0, 1'b0);
        queue_item(8'h56, 9'd5,   1'b1, 1'b0);
        queue_item(8'h78, 9'd0,   1'b0, 1'b1);
        queue_item(8'hC3, 9'd2,   1'b1, 1'b0);
        queue_item(8'h3C, 9'd0,   1'b0, 1'b1);
        queue_item(8'hFE, 9'd257, 1'b0, 1'b0);
        queue_item(8'hEF, 9'd0,   1'b0, 1'b1);
        wait_drained();

        write_encoding(1'b1);
        tx_idle_pct = 9;
        rx_idle_pct = 70;
        queue_random_messages(RANDOM_ITEMS);
        wait_drained();

        write_encoding(1'b0);
        tx_idle_pct = 70;
        rx_idle_pct = 9;
        queue_random_messages(RANDOM_ITEMS);
        wait_drained();

        write_encoding(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_requests++;
        queue_random_messages(RANDOM_ITEMS);
        wait_drained();

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && frame_expected.size() == 0) begin
            $display("tts_command_framer regression: pass");
        end else begin
            $display("tts_command_framer regression: fail");
        end
        $finish;
    end
endmodule
